>>> rtl/md5h_pkg.sv
// md5h_pkg: shared types, constants and tables of the md5 stream hash
// used by md5h_round, md5h_pad and md5_stream_hash
`timescale 1ns / 1ps
`default_nettype none

package md5h_pkg;

  localparam int ByteW         = 8;
  localparam int WordW         = 32;
  localparam int LaneCnt       = 4;
  localparam int WordsPerBlock = 16;
  localparam int BlockBytes    = 64;

  localparam logic [WordW-1:0] Iv [LaneCnt] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [ByteW-1:0] PadMarker  = 8'h80;
  localparam logic [6:0]       OneBlockMax = 7'd55;
  localparam logic [5:0]       BlockLast   = 6'd63;
  localparam logic [6:0]       FullBlock   = 7'd64;

  // per-compression message assembly control
  typedef struct packed {
    logic [6:0] valid_len;
    logic       mark;
    logic       len_en;
  } pad_ctl_t;

  function automatic logic [WordW-1:0] round_const(input logic [5:0] idx);
    logic [WordW-1:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] idx);
    logic [4:0] s;
    unique case ({idx[5:4], idx[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = '0;
    endcase
    return s;
  endfunction

  // message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] g;
    unique case (idx[5:4])
      2'd0:    g = idx[3:0];
      2'd1:    g = 4'(idx[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(idx[3:0] * 4'd3 + 4'd5);
      2'd3:    g = 4'(idx[3:0] * 4'd7);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/md5h_ram.sv
// md5h_ram: generic single write, single read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module md5h_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/md5h_round.sv
// md5h_round: one md5 step, shared by all 64 rounds of a compression
// depends on md5h_pkg for the round constants and rotate amounts
`timescale 1ns / 1ps
`default_nettype none

module md5h_round
  import md5h_pkg::*;
(
  input  wire logic [5:0]       rnd,
  input  wire logic [WordW-1:0] a,
  input  wire logic [WordW-1:0] b,
  input  wire logic [WordW-1:0] c,
  input  wire logic [WordW-1:0] d,
  input  wire logic [WordW-1:0] w,
  output logic      [WordW-1:0] b_new
);

  logic [WordW-1:0]   f;
  logic [WordW-1:0]   sum;
  logic [2*WordW-1:0] rot;

  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = '0;
    endcase
  end

  assign sum   = a + f + round_const(rnd) + w;
  assign rot   = {sum, sum} << rot_amount(rnd);
  assign b_new = b + rot[2*WordW-1:WordW];

endmodule

`default_nettype wire

>>> rtl/md5h_pad.sv
// md5h_pad: builds a message word from stored bytes, the 0x80 marker,
// zero fill and the little-endian bit count; depends on md5h_pkg
`timescale 1ns / 1ps
`default_nettype none

module md5h_pad
  import md5h_pkg::*;
(
  input  wire logic [3:0]               word_idx,
  input  wire logic [WordW-1:0]         ram_word,
  input  wire pad_ctl_t                 ctl,
  input  wire logic [2*WordW-1:0]       byte_total,
  output logic      [WordW-1:0]         word
);

  logic [2*WordW-1:0] bit_count;

  assign bit_count = {byte_total[2*WordW-4:0], 3'b000};

  always_comb begin
    logic [5:0] bidx;
    bidx = '0;
    word = '0;
    for (int j = 0; j < LaneCnt; j++) begin
      bidx = {word_idx, j[1:0]};
      if ({1'b0, bidx} < ctl.valid_len) begin
        word[ByteW*j +: ByteW] = ram_word[ByteW*j +: ByteW];
      end else if (ctl.mark && ({1'b0, bidx} == ctl.valid_len)) begin
        word[ByteW*j +: ByteW] = PadMarker;
      end else if (ctl.len_en && (bidx[5:3] == 3'b111)) begin
        word[ByteW*j +: ByteW] = bit_count[{bidx[2:0], 3'b000} +: ByteW];
      end else begin
        word[ByteW*j +: ByteW] = '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/md5_stream_hash.sv
// md5_stream_hash: top level, byte intake, compression sequencer, digest output
// depends on md5h_pkg, md5h_ram, md5h_round and md5h_pad
`timescale 1ns / 1ps
`default_nettype none

// MD5 over a byte stream, one message byte per input beat. A beat that does
// not complete a 64-byte block is taken with no hold-off. A beat that
// completes a block holds off input to start the message word read, run 64
// rounds through the single round unit at one MD5 step per cycle, and add
// into the chaining value. A finish beat runs one padding compression, or
// two when 56 or more bytes of the last block are used, then loads the
// digest register; the block then takes input again while the digest waits
// on the output. Padding is built on the fly, so stale block bytes are never
// used. The digest comes out as two little-endian 64-bit halves.

module md5_stream_hash
  import md5h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_digest_lo,
  output logic [63:0]      out_digest_hi
);

  localparam logic [1:0] OP_ABSORB        = 2'd0;
  localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] OP_FINISH        = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FINAL, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    AFT_IDLE, AFT_FINISH, AFT_PAD2, AFT_DIGEST
  } after_t;

  state_t           state_r,  state_nxt;
  after_t           after_r,  after_nxt;
  pad_ctl_t         ctl_r,    ctl_nxt;
  logic [5:0]       rnd_r,    rnd_nxt;
  logic [WordW-1:0] chain_r [LaneCnt];
  logic [WordW-1:0] chain_nxt [LaneCnt];
  logic [WordW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [63:0]      byte_total_r, byte_total_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_digest_lo_r, out_digest_lo_nxt;
  logic [63:0]      out_digest_hi_r, out_digest_hi_nxt;

  logic             accept;
  logic             wr_byte;
  logic             emit_go;
  logic [5:0]       pos;
  logic [6:0]       fin_pos;
  logic [5:0]       rd_idx;
  logic [3:0]       rd_addr;
  logic             rd_en;
  logic [WordW-1:0] ram_word;
  logic [WordW-1:0] msg_word;
  logic [WordW-1:0] round_b;

  assign pos      = byte_total_r[5:0];
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_byte  = accept && ((in_op == OP_ABSORB) || (in_op == OP_ABSORB_FINISH));
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign fin_pos  = (in_op == OP_ABSORB_FINISH) ? ({1'b0, pos} + 7'd1) : {1'b0, pos};

  // message word read, one round ahead of the round that uses it
  assign rd_idx  = (state_r == ST_ROUND) ? (rnd_r + 6'd1) : 6'd0;
  assign rd_addr = msg_index(rd_idx);
  assign rd_en   = (state_r == ST_LOAD) || (state_r == ST_ROUND);

  for (genvar j = 0; j < LaneCnt; j++) begin : g_lane
    md5h_ram #(
      .Width (ByteW),
      .Depth (WordsPerBlock)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_byte && (pos[1:0] == 2'(j))),
      .wr_addr (pos[5:2]),
      .wr_data (in_data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_word[ByteW*j +: ByteW])
    );
  end

  md5h_pad u_pad (
    .word_idx   (msg_index(rnd_r)),
    .ram_word   (ram_word),
    .ctl        (ctl_r),
    .byte_total (byte_total_r),
    .word       (msg_word)
  );

  md5h_round u_round (
    .rnd   (rnd_r),
    .a     (a_r),
    .b     (b_r),
    .c     (c_r),
    .d     (d_r),
    .w     (msg_word),
    .b_new (round_b)
  );

  always_comb begin
    state_nxt         = state_r;
    after_nxt         = after_r;
    ctl_nxt           = ctl_r;
    rnd_nxt           = rnd_r;
    chain_nxt         = chain_r;
    a_nxt             = a_r;
    b_nxt             = b_r;
    c_nxt             = c_r;
    d_nxt             = d_r;
    byte_total_nxt    = byte_total_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_digest_lo_nxt = out_digest_lo_r;
    out_digest_hi_nxt = out_digest_hi_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (wr_byte) begin
            byte_total_nxt = byte_total_r + 64'd1;
          end
          case (in_op) inside
            OP_ABSORB: begin
              if (pos == BlockLast) begin
                ctl_nxt   = '{valid_len: FullBlock, mark: 1'b0, len_en: 1'b0};
                after_nxt = AFT_IDLE;
                state_nxt = ST_LOAD;
              end
            end
            OP_ABSORB_FINISH, OP_FINISH: begin
              state_nxt = ST_LOAD;
              if ((in_op == OP_ABSORB_FINISH) && (pos == BlockLast)) begin
                ctl_nxt   = '{valid_len: FullBlock, mark: 1'b0, len_en: 1'b0};
                after_nxt = AFT_FINISH;
              end else if (fin_pos <= OneBlockMax) begin
                ctl_nxt   = '{valid_len: fin_pos, mark: 1'b1, len_en: 1'b1};
                after_nxt = AFT_DIGEST;
              end else begin
                ctl_nxt   = '{valid_len: fin_pos, mark: 1'b1, len_en: 1'b0};
                after_nxt = AFT_PAD2;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        a_nxt   = d_r;
        b_nxt   = round_b;
        c_nxt   = b_r;
        d_nxt   = c_r;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == BlockLast) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        unique case (after_r)
          AFT_IDLE: begin
            state_nxt = ST_IDLE;
          end
          AFT_FINISH: begin
            ctl_nxt   = '{valid_len: 7'd0, mark: 1'b1, len_en: 1'b1};
            after_nxt = AFT_DIGEST;
            state_nxt = ST_LOAD;
          end
          AFT_PAD2: begin
            ctl_nxt   = '{valid_len: 7'd0, mark: 1'b0, len_en: 1'b1};
            after_nxt = AFT_DIGEST;
            state_nxt = ST_LOAD;
          end
          AFT_DIGEST: begin
            state_nxt = ST_EMIT;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt     = 1'b1;
          out_digest_lo_nxt = {chain_r[1], chain_r[0]};
          out_digest_hi_nxt = {chain_r[3], chain_r[2]};
          chain_nxt         = Iv;
          byte_total_nxt    = '0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ctl_r           <= ctl_nxt;
    rnd_r           <= rnd_nxt;
    a_r             <= a_nxt;
    b_r             <= b_nxt;
    c_r             <= c_nxt;
    d_r             <= d_nxt;
    out_digest_lo_r <= out_digest_lo_nxt;
    out_digest_hi_r <= out_digest_hi_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      after_r      <= AFT_IDLE;
      chain_r      <= Iv;
      byte_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      after_r      <= after_nxt;
      chain_r      <= chain_nxt;
      byte_total_r <= byte_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_digest_lo = out_digest_lo_r;
  assign out_digest_hi = out_digest_hi_r;

`ifndef SYNTHESIS
  a_load_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> ((state_r == ST_ROUND) && (rnd_r == 6'd0)))
    else $error("round counter not restarted on load");

  a_last_round_final: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ROUND) && (rnd_r == BlockLast)) |=> (state_r == ST_FINAL))
    else $error("compression did not end after 64 rounds");

  a_digest_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("digest beat raised outside emit");

  a_emit_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> ((byte_total_r == 64'd0) && (chain_r[0] == Iv[0]) &&
                 (state_r == ST_IDLE)))
    else $error("context not reinitialized after digest");

  a_finish_pads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_FINISH)) |=> ((state_r == ST_LOAD) && ctl_r.mark))
    else $error("finish beat did not start padding");
`endif

endmodule

`default_nettype wire
